// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them out.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OPU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OPU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OPU_ASSERT_IMP(lbl, ante, cons)
`define OPU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/opu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package opu_pkg;

    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 24;
    localparam int WIDE_W  = 64;
    localparam int MODE_W  = 2;
    localparam int DECAY_W = 16;
    localparam int LR_W    = 24;
    localparam int EPS_W   = 24;
    localparam int BATCH_W = 16;
    localparam int ROOT_W  = (VALUE_W + FRAC_W) / 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SGD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RMS  = 2'd2;

    localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_DECAY = 3'd1;
    localparam logic [IDX_W-1:0] REG_LR    = 3'd2;
    localparam logic [IDX_W-1:0] REG_EPS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_BATCH = 3'd4;

    localparam logic [MODE_W-1:0]  MODE_RST  = MODE_PASS;
    localparam logic [DECAY_W-1:0] DECAY_RST = 16'd58982;
    localparam logic [LR_W-1:0]    LR_RST    = 24'd167772;
    localparam logic [EPS_W-1:0]   EPS_RST   = 24'd1;
    localparam logic [BATCH_W-1:0] BATCH_RST = 16'd1;

    localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] param;
        logic signed [VALUE_W-1:0] moment;
    } pm_t;

    typedef struct packed {
        logic neg;
        pm_t  pm;
    } div_side_t;

    typedef struct packed {
        pm_t                       pm;
        logic signed [VALUE_W-1:0] g;
        logic signed [VALUE_W-1:0] mnew;
    } sq_side_t;

    typedef struct packed {
        sq_side_t s;
        logic     ovf;
    } quo_side_t;

    // clamp a wide signed value to the value range
    function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [WIDE_W-1:0] x);
        logic [WIDE_W-VALUE_W:0] top;
        top = x[WIDE_W-1:VALUE_W-1];
        if (top == '0 || top == '1)
            return x[VALUE_W-1:0];
        else if (x[WIDE_W-1])
            return VMIN;
        else
            return VMAX;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/opu_udiv_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage.
module opu_udiv_pipe import opu_pkg::*; #(
    parameter int QW     = 32,
    parameter int DW     = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [DW-1:0]     in_rem,
    input  wire logic [QW-1:0]     in_num,
    input  wire logic [DW-1:0]     in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [QW-1:0]          out_quo,
    output logic [SIDE_W-1:0]      out_side
);

    logic              valid_reg [QW];
    logic [DW-1:0]     rem_reg   [QW];
    logic [QW-1:0]     num_reg   [QW];
    logic [DW-1:0]     den_reg   [QW];
    logic [SIDE_W-1:0] side_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic              valid_src;
        logic [DW-1:0]     rem_src;
        logic [QW-1:0]     num_src;
        logic [DW-1:0]     den_src;
        logic [SIDE_W-1:0] side_src;
        logic [DW:0]       trial;
        logic              ge;
        logic [DW-1:0]     rem_next;
        logic [QW-1:0]     num_next;

        if (k == 0) begin : g_first
            assign valid_src = in_valid;
            assign rem_src   = in_rem;
            assign num_src   = in_num;
            assign den_src   = in_den;
            assign side_src  = in_side;
        end else begin : g_rest
            assign valid_src = valid_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign num_src   = num_reg[k-1];
            assign den_src   = den_reg[k-1];
            assign side_src  = side_reg[k-1];
        end

        assign trial    = {rem_src, num_src[QW-1]};
        assign ge       = trial >= {1'b0, den_src};
        assign rem_next = ge ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
        // quotient bits shift in where numerator bits leave
        assign num_next = {num_src[QW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv)
                valid_reg[k] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= num_next;
                den_reg[k]  <= den_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = num_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
`default_nettype wire

// ===== rtl/opu_isqrt_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Digit-by-digit integer square root, one root bit per stage.
module opu_isqrt_pipe import opu_pkg::*; #(
    parameter int RW     = ROOT_W,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [2*RW-1:0]   in_x,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [RW-1:0]          out_root,
    output logic [SIDE_W-1:0]      out_side
);

    logic              valid_reg [RW];
    logic [2*RW-1:0]   x_reg     [RW];
    logic [RW:0]       rem_reg   [RW];
    logic [RW-1:0]     root_reg  [RW];
    logic [SIDE_W-1:0] side_reg  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic              valid_src;
        logic [2*RW-1:0]   x_src;
        logic [RW:0]       rem_src;
        logic [RW-1:0]     root_src;
        logic [SIDE_W-1:0] side_src;
        logic [RW+2:0]     trial;
        logic [RW+2:0]     test;
        logic              ge;
        logic [RW:0]       rem_next;
        logic [RW-1:0]     root_next;

        if (k == 0) begin : g_first
            assign valid_src = in_valid;
            assign x_src     = in_x;
            assign rem_src   = '0;
            assign root_src  = '0;
            assign side_src  = in_side;
        end else begin : g_rest
            assign valid_src = valid_reg[k-1];
            assign x_src     = x_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign root_src  = root_reg[k-1];
            assign side_src  = side_reg[k-1];
        end

        assign trial     = {rem_src, x_src[2*RW-1-2*k -: 2]};
        assign test      = {1'b0, root_src, 2'b01};
        assign ge        = trial >= test;
        assign rem_next  = ge ? (RW+1)'(trial - test) : trial[RW:0];
        assign root_next = {root_src[RW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv)
                valid_reg[k] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k]    <= x_src;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule
`default_nettype wire

// ===== rtl/opu_moment.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Moment update: signed gradient and square, decay products, round and saturate.
module opu_moment import opu_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic [MODE_W-1:0]         mode,
    input  wire logic [DECAY_W-1:0]        decay,
    input  wire logic                      in_valid,
    input  wire logic [VALUE_W-1:0]        in_quo,
    input  wire logic                      in_neg,
    input  wire logic signed [VALUE_W-1:0] in_m,
    input  wire logic [SIDE_W-1:0]         in_side,
    output logic                           out_valid,
    output logic signed [VALUE_W-1:0]      out_g,
    output logic signed [VALUE_W-1:0]      out_mnew,
    output logic [SIDE_W-1:0]              out_side
);

    localparam int SQ_W   = 2 * VALUE_W;
    localparam int G2_W   = SQ_W - FRAC_W;
    localparam int OMB_W  = DECAY_W + 1;
    localparam int PB_W   = OMB_W + VALUE_W;
    localparam int PO_W   = OMB_W + 1 + G2_W;
    localparam int SUM_W  = PO_W + 1;

    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [VALUE_W-1:0] g1_reg, g2s_reg, m1_reg;
    logic [SQ_W-1:0]           sq1_reg;
    logic [SIDE_W-1:0]         side1_reg, side2_reg, side3_reg;
    logic signed [PB_W-1:0]    pb_reg;
    logic signed [PO_W-1:0]    po_reg;
    logic signed [VALUE_W-1:0] mnew_reg;

    logic signed [VALUE_W-1:0] g1_next;
    logic [SQ_W-1:0]           sq_rnd;
    logic signed [G2_W-1:0]    g2;
    logic signed [G2_W-1:0]    sel;
    logic [OMB_W-1:0]          omb;
    logic signed [PB_W-1:0]    pb_next;
    logic signed [PO_W-1:0]    po_next;
    logic signed [SUM_W-1:0]   sum;
    logic signed [VALUE_W-1:0] mnew_next;

    assign g1_next = in_neg ? VALUE_W'(-in_quo) : in_quo;

    // g^2 back to Q16.24, ties up; the square never reaches the top bit
    assign sq_rnd  = sq1_reg + SQ_W'(1 << (FRAC_W - 1));
    assign g2      = {1'b0, sq_rnd[SQ_W-2:FRAC_W]};
    assign sel     = (mode == MODE_RMS) ? g2 : G2_W'(g1_reg);
    assign omb     = {1'b1, {DECAY_W{1'b0}}} - {1'b0, decay};
    assign pb_next = $signed({1'b0, decay}) * m1_reg;
    assign po_next = $signed({1'b0, omb}) * sel;

    assign sum       = SUM_W'(pb_reg) + SUM_W'(po_reg) + SUM_W'(1 << 15);
    assign mnew_next = sat_value(WIDE_W'(sum >>> 16));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_reg    <= g1_next;
            sq1_reg   <= in_quo * in_quo;
            m1_reg    <= in_m;
            side1_reg <= in_side;
            pb_reg    <= pb_next;
            po_reg    <= po_next;
            g2s_reg   <= g1_reg;
            side2_reg <= side1_reg;
            mnew_reg  <= mnew_next;
            side3_reg <= side2_reg;
            out_g     <= g2s_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_mnew  = mnew_reg;
    assign out_side  = side3_reg;

endmodule
`default_nettype wire

// ===== rtl/optimizer_param_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Per-element SGD-momentum / RMSprop parameter update on Q8.24 values. One item enters
// per cycle while the pipeline is not held and passes through the batch-size divider, the
// moment datapath, the square-root pipeline, the root divider and the parameter step,
// one bit per stage in each divider and root unit. The whole pipeline holds while a
// finished result waits on out_ready; a bubble keeps its slot.
// Registers sit on the APB port at 0x00 mode, 0x04 decay, 0x08 step size,
// 0x0C epsilon, 0x10 batch_size and should be written only while the block is empty.
module optimizer_param_update import opu_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]              prdata,
    output logic                           pready,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [VALUE_W-1:0] param_value,
    input  wire logic signed [VALUE_W-1:0] grad_sum,
    input  wire logic signed [VALUE_W-1:0] moment_in,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [VALUE_W-1:0]      param_out,
    output logic signed [VALUE_W-1:0]      moment_out
);

    localparam int PROD_W = LR_W + 1 + VALUE_W;
    localparam int STEP_W = PROD_W - FRAC_W;
    localparam int DIFF_W = STEP_W + 1;

    logic [MODE_W-1:0]  mode_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic [LR_W-1:0]    lr_reg;
    logic [EPS_W-1:0]   eps_reg;
    logic [BATCH_W-1:0] batch_reg;

    logic              cfg_wr;
    logic [IDX_W-1:0]  cfg_idx;
    logic              adv;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RST;
            decay_reg <= DECAY_RST;
            lr_reg    <= LR_RST;
            eps_reg   <= EPS_RST;
            batch_reg <= BATCH_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MODE:  mode_reg  <= pwdata[MODE_W-1:0];
                REG_DECAY: decay_reg <= pwdata[DECAY_W-1:0];
                REG_LR:    lr_reg    <= pwdata[LR_W-1:0];
                REG_EPS:   eps_reg   <= pwdata[EPS_W-1:0];
                REG_BATCH: batch_reg <= pwdata[BATCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MODE:  prdata = DATA_W'(mode_reg);
            REG_DECAY: prdata = DATA_W'(decay_reg);
            REG_LR:    prdata = DATA_W'(lr_reg);
            REG_EPS:   prdata = DATA_W'(eps_reg);
            REG_BATCH: prdata = DATA_W'(batch_reg);
            default:   prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] param_out_reg, moment_out_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ---------------- g = grad_sum / batch ----------------
    logic [VALUE_W-1:0] gs_mag;
    logic [BATCH_W-1:0] den1;
    div_side_t          d1_in_side, d1_out_side;
    logic               d1_valid;
    logic [VALUE_W-1:0] d1_quo;

    assign gs_mag            = grad_sum[VALUE_W-1] ? VALUE_W'(-grad_sum) : grad_sum;
    assign den1              = (batch_reg == '0) ? BATCH_W'(1) : batch_reg;
    assign d1_in_side.neg    = grad_sum[VALUE_W-1];
    assign d1_in_side.pm     = '{param: param_value, moment: moment_in};

    opu_udiv_pipe #(
        .QW     (VALUE_W),
        .DW     (BATCH_W),
        .SIDE_W ($bits(div_side_t))
    ) u_div_batch (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_rem    ('0),
        .in_num    (gs_mag),
        .in_den    (den1),
        .in_side   (d1_in_side),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_side  (d1_out_side)
    );

    // ---------------- moment ----------------
    logic                      mo_valid;
    logic signed [VALUE_W-1:0] mo_g, mo_mnew;
    pm_t                       mo_pm;

    opu_moment #(
        .SIDE_W ($bits(pm_t))
    ) u_moment (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .mode      (mode_reg),
        .decay     (decay_reg),
        .in_valid  (d1_valid),
        .in_quo    (d1_quo),
        .in_neg    (d1_out_side.neg),
        .in_m      (d1_out_side.pm.moment),
        .in_side   (d1_out_side.pm),
        .out_valid (mo_valid),
        .out_g     (mo_g),
        .out_mnew  (mo_mnew),
        .out_side  (mo_pm)
    );

    // ---------------- root of (moment + epsilon) ----------------
    logic signed [VALUE_W:0] rad;
    logic [VALUE_W-1:0]      rad_u;
    logic [2*ROOT_W-1:0]     sq_x;
    sq_side_t                sq_in_side, sq_out_side;
    logic                    sq_valid;
    logic [ROOT_W-1:0]       sq_root;

    assign rad   = (VALUE_W+1)'(mo_mnew) + (VALUE_W+1)'(eps_reg);
    assign rad_u = rad[VALUE_W] ? '0 : rad[VALUE_W-1:0];
    assign sq_x  = (2*ROOT_W)'({rad_u, {FRAC_W{1'b0}}});
    assign sq_in_side = '{pm: mo_pm, g: mo_g, mnew: mo_mnew};

    opu_isqrt_pipe #(
        .RW     (ROOT_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mo_valid),
        .in_x      (sq_x),
        .in_side   (sq_in_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_out_side)
    );

    // ---------------- g * 2^24 / root ----------------
    logic [VALUE_W-1:0] g_mag;
    logic [ROOT_W-1:0]  rem2;
    quo_side_t          d2_in_side, d2_out_side;
    logic               d2_valid;
    logic [VALUE_W-1:0] d2_quo;

    assign g_mag = sq_out_side.g[VALUE_W-1] ? VALUE_W'(-sq_out_side.g) : sq_out_side.g;
    assign rem2  = ROOT_W'(g_mag[VALUE_W-1:VALUE_W-FRAC_W]);
    // quotient would need more than VALUE_W bits (also covers a zero root)
    assign d2_in_side.s   = sq_out_side;
    assign d2_in_side.ovf = rem2 >= sq_root;

    opu_udiv_pipe #(
        .QW     (VALUE_W),
        .DW     (ROOT_W),
        .SIDE_W ($bits(quo_side_t))
    ) u_div_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_rem    (rem2),
        .in_num    ({g_mag[VALUE_W-FRAC_W-1:0], {FRAC_W{1'b0}}}),
        .in_den    (sq_root),
        .in_side   (d2_in_side),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_side  (d2_out_side)
    );

    // ---------------- parameter step ----------------
    logic                      f1_valid_reg, f2_valid_reg;
    logic signed [VALUE_W-1:0] term_reg;
    pm_t                       f1_pm_reg, f2_pm_reg;
    logic signed [VALUE_W-1:0] f1_mnew_reg, f2_mnew_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic signed [VALUE_W-1:0] q_sat;
    logic signed [VALUE_W-1:0] term_next;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [STEP_W-1:0]  step;
    logic signed [DIFF_W-1:0]  diff;
    logic                      pass;

    always_comb
    begin
        if (d2_out_side.s.g == '0)
            q_sat = '0;
        else if (!d2_out_side.s.g[VALUE_W-1])
            q_sat = (d2_out_side.ovf || d2_quo[VALUE_W-1]) ? VMAX : d2_quo;
        else if (d2_out_side.ovf || d2_quo > VMIN)
            q_sat = VMIN;
        else
            q_sat = VALUE_W'(-d2_quo);
    end

    assign term_next = (mode_reg == MODE_SGD) ? d2_out_side.s.mnew : q_sat;
    assign prod_rnd  = prod_reg + PROD_W'(1 << (FRAC_W - 1));
    assign step      = prod_rnd[PROD_W-1:FRAC_W];
    assign diff      = DIFF_W'(f2_pm_reg.param) - DIFF_W'(step);
    assign pass      = (mode_reg != MODE_SGD) && (mode_reg != MODE_RMS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg  <= d2_valid;
            f2_valid_reg  <= f1_valid_reg;
            out_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_reg       <= term_next;
            f1_pm_reg      <= d2_out_side.s.pm;
            f1_mnew_reg    <= d2_out_side.s.mnew;
            prod_reg       <= $signed({1'b0, lr_reg}) * term_reg;
            f2_pm_reg      <= f1_pm_reg;
            f2_mnew_reg    <= f1_mnew_reg;
            param_out_reg  <= pass ? f2_pm_reg.param : sat_value(WIDE_W'(diff));
            moment_out_reg <= pass ? f2_pm_reg.moment : f2_mnew_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign param_out  = param_out_reg;
    assign moment_out = moment_out_reg;

    `OPU_ASSERT_IMP(a_backpressure, out_valid_reg && !out_ready, !in_ready)
    `OPU_ASSERT_IMP(a_empty_takes, !out_valid_reg, in_ready)
    `OPU_ASSERT_NXT(a_root_holds, sq_valid && !adv, sq_valid && $stable(sq_root))

endmodule
`default_nettype wire
